/* rtl/bcpe_pkg.sv */
package bcpe_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int PT_FRAC        = 8;
    localparam int DEGREE         = 3;
    localparam int NUM_AXES       = 2;
    // input reg + two stages per level + output reg
    localparam int LATENCY        = 2 * DEGREE + 2;

endpackage

/* rtl/bcpe_lerp.sv */
module bcpe_lerp #(
    parameter int PW        = bcpe_pkg::COORD_BITS_DEF + bcpe_pkg::PT_FRAC,
    parameter int FRAC_BITS = bcpe_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic signed [PW-1:0]  i_a,
    input  logic signed [PW-1:0]  i_b,
    input  logic [FRAC_BITS:0]    i_t,
    output logic signed [PW-1:0]  o_y
);
    import bcpe_pkg::*;

    localparam int DW = PW + 1;
    localparam int TW = FRAC_BITS + 1;
    localparam int MW = DW + TW + 1;

    logic signed [DW-1:0] d;
    logic signed [TW:0]   ts;
    logic signed [MW-1:0] n_prod;
    logic signed [MW-1:0] r_prod;
    logic signed [PW-1:0] r_a;
    logic signed [MW-1:0] rnd;
    logic signed [MW-1:0] shifted;
    logic signed [PW-1:0] n_y;
    logic signed [PW-1:0] r_y;

    // stage 1: difference times t
    assign d      = DW'(i_b) - DW'(i_a);
    assign ts     = {1'b0, i_t};
    assign n_prod = MW'(d) * MW'(ts);

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_a    <= i_a;
    end

    // stage 2: round half up, drop t fraction, add base
    assign rnd     = r_prod + MW'(2 ** (FRAC_BITS - 1));
    assign shifted = rnd >>> FRAC_BITS;
    assign n_y     = r_a + PW'(shifted);

    always_ff @(posedge i_clk) begin
        r_y <= n_y;
    end

    assign o_y = r_y;

endmodule

/* rtl/cubic_bezier_point_eval.sv */
// Cubic Bezier / straight line point evaluator.
// Command channel: drive the action, the four control points and t, and pulse
// start. busy is held low, so a command is taken at every edge where start is
// high; one new transfer may be issued every cycle.
// Result channel: o_valid is high for exactly one cycle with o_point_x and
// o_point_y. The receiver cannot stall; each result must be taken in the cycle
// it is shown.
// Throughput is one point per cycle, set by the fully pipelined lerp units. Each
// command passes the input register, three de Casteljau levels of two stages
// each (multiply, then round and add), and the output rounding register, and its
// result is shown once that last register is loaded.
// Action 0 interpolates p0..p1 once; the later levels then see equal end points
// and pass the value through. t above one is clamped to one.
// Reset (synchronous, active low) clears all valid bits; commands in flight are
// dropped and no strobe appears until a new command has passed the pipeline.
module cubic_bezier_point_eval #(
    parameter int COORD_BITS = bcpe_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = bcpe_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_action,
    input  logic signed [COORD_BITS-1:0] i_p0_x,
    input  logic signed [COORD_BITS-1:0] i_p0_y,
    input  logic signed [COORD_BITS-1:0] i_p1_x,
    input  logic signed [COORD_BITS-1:0] i_p1_y,
    input  logic signed [COORD_BITS-1:0] i_p2_x,
    input  logic signed [COORD_BITS-1:0] i_p2_y,
    input  logic signed [COORD_BITS-1:0] i_p3_x,
    input  logic signed [COORD_BITS-1:0] i_p3_y,
    input  logic [FRAC_BITS:0]           i_t,
    output logic                         o_valid,
    output logic signed [COORD_BITS-1:0] o_point_x,
    output logic signed [COORD_BITS-1:0] o_point_y
);
    import bcpe_pkg::*;

    localparam int PW  = COORD_BITS + PT_FRAC;
    localparam int TW  = FRAC_BITS + 1;
    localparam int NV  = 2 * DEGREE + 1;
    localparam logic [TW-1:0] T_ONE = TW'(1) << FRAC_BITS;

    logic                         accept;
    logic signed [COORD_BITS-1:0] p_in [NUM_AXES][DEGREE+1];
    logic [TW-1:0]                t_clamp;

    logic [NV-1:0]                r_vld;
    logic [TW-1:0]                r_t     [2*DEGREE-1];
    logic                         r_cubic [3];
    logic signed [PW-1:0]         r0_w    [NUM_AXES][DEGREE+1];

    logic signed [PW-1:0]         l1   [NUM_AXES][3];
    logic signed [PW-1:0]         sel1 [NUM_AXES][3];
    logic signed [PW-1:0]         l2   [NUM_AXES][2];
    logic signed [PW-1:0]         l3   [NUM_AXES];
    logic signed [PW-1:0]         rnd  [NUM_AXES];

    logic                         r_out_vld;
    logic signed [COORD_BITS-1:0] r_point [NUM_AXES];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign p_in[0][0] = i_p0_x;
    assign p_in[0][1] = i_p1_x;
    assign p_in[0][2] = i_p2_x;
    assign p_in[0][3] = i_p3_x;
    assign p_in[1][0] = i_p0_y;
    assign p_in[1][1] = i_p1_y;
    assign p_in[1][2] = i_p2_y;
    assign p_in[1][3] = i_p3_y;

    assign t_clamp = (i_t > T_ONE) ? T_ONE : i_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[NV-2:0], accept};
            r_out_vld <= r_vld[NV-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_t[0]     <= t_clamp;
        r_cubic[0] <= i_action;
        for (int k = 1; k < 2 * DEGREE - 1; k++) begin
            r_t[k] <= r_t[k-1];
        end
        for (int k = 1; k < 3; k++) begin
            r_cubic[k] <= r_cubic[k-1];
        end
        for (int a = 0; a < NUM_AXES; a++) begin
            for (int j = 0; j <= DEGREE; j++) begin
                r0_w[a][j] <= {p_in[a][j], PT_FRAC'(0)};
            end
        end
    end

    generate
        for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
            for (genvar j = 0; j < 3; j++) begin : g_l1
                bcpe_lerp #(.PW(PW), .FRAC_BITS(FRAC_BITS)) u_lerp (
                    .i_clk (i_clk),
                    .i_a   (r0_w[a][j]),
                    .i_b   (r0_w[a][j+1]),
                    .i_t   (r_t[0]),
                    .o_y   (l1[a][j])
                );
                // line: collapse to the single p0..p1 point
                assign sel1[a][j] = r_cubic[2] ? l1[a][j] : l1[a][0];
            end
            for (genvar j = 0; j < 2; j++) begin : g_l2
                bcpe_lerp #(.PW(PW), .FRAC_BITS(FRAC_BITS)) u_lerp (
                    .i_clk (i_clk),
                    .i_a   (sel1[a][j]),
                    .i_b   (sel1[a][j+1]),
                    .i_t   (r_t[2]),
                    .o_y   (l2[a][j])
                );
            end
            bcpe_lerp #(.PW(PW), .FRAC_BITS(FRAC_BITS)) u_lerp3 (
                .i_clk (i_clk),
                .i_a   (l2[a][0]),
                .i_b   (l2[a][1]),
                .i_t   (r_t[4]),
                .o_y   (l3[a])
            );
            assign rnd[a] = l3[a] + PW'(2 ** (PT_FRAC - 1));
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < NUM_AXES; a++) begin
            r_point[a] <= rnd[a][PW-1:PT_FRAC];
        end
    end

    assign o_valid   = r_out_vld;
    assign o_point_x = r_point[0];
    assign o_point_y = r_point[1];

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(LATENCY) o_valid)
        else $error("command transfer did not produce a result on time");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_vld[NV-1]))
        else $error("result strobe without a command in the last stage");

    a_t_zero_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && $past(r_t[0] == '0, 2)) |-> (l1[0][0] == $past(r0_w[0][0], 2)))
        else $error("lerp at t zero did not return its start point (x)");

    a_t_zero_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && $past(r_t[0] == '0, 2)) |-> (l1[1][0] == $past(r0_w[1][0], 2)))
        else $error("lerp at t zero did not return its start point (y)");
`endif

endmodule

/* dv/bezier_point_checker.sv */
`timescale 1ns / 1ps

module bezier_point_checker
    import bcpe_pkg::*;
(
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             cmd_start,
    input  logic                             cmd_busy,
    input  logic                             cmd_action,
    input  logic signed [COORD_BITS_DEF-1:0] cmd_p0_x,
    input  logic signed [COORD_BITS_DEF-1:0] cmd_p0_y,
    input  logic signed [COORD_BITS_DEF-1:0] cmd_p1_x,
    input  logic signed [COORD_BITS_DEF-1:0] cmd_p1_y,
    input  logic signed [COORD_BITS_DEF-1:0] cmd_p2_x,
    input  logic signed [COORD_BITS_DEF-1:0] cmd_p2_y,
    input  logic signed [COORD_BITS_DEF-1:0] cmd_p3_x,
    input  logic signed [COORD_BITS_DEF-1:0] cmd_p3_y,
    input  logic [FRAC_BITS_DEF:0]           cmd_t,
    input  logic                             res_valid,
    input  logic signed [COORD_BITS_DEF-1:0] res_x,
    input  logic signed [COORD_BITS_DEF-1:0] res_y,
    output int                               mismatch_count,
    output int                               pending_count
);

    localparam int CW = COORD_BITS_DEF;
    localparam int FW = FRAC_BITS_DEF;
    localparam longint T_ONE = longint'(1) << FW;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_point;

    t_point expected_points[$];

    // a + round_half_up((b - a) * t / 2^FW), a and b in Q.8
    function automatic longint lerp_q8(longint a, longint b, longint t);
        return a + (((b - a) * t + (longint'(1) << (FW - 1))) >>> FW);
    endfunction

    function automatic logic signed [CW-1:0] axis_point(
        logic cubic,
        logic signed [CW-1:0] c0, logic signed [CW-1:0] c1,
        logic signed [CW-1:0] c2, logic signed [CW-1:0] c3,
        logic [FW:0] t_raw
    );
        longint w0, w1, w2, w3, tt, r;
        tt = (longint'(t_raw) > T_ONE) ? T_ONE : longint'(t_raw);
        w0 = longint'(c0) * (longint'(1) << PT_FRAC);
        w1 = longint'(c1) * (longint'(1) << PT_FRAC);
        w2 = longint'(c2) * (longint'(1) << PT_FRAC);
        w3 = longint'(c3) * (longint'(1) << PT_FRAC);
        if (!cubic) begin
            w0 = lerp_q8(w0, w1, tt);
        end else begin
            w0 = lerp_q8(w0, w1, tt);
            w1 = lerp_q8(w1, w2, tt);
            w2 = lerp_q8(w2, w3, tt);
            w0 = lerp_q8(w0, w1, tt);
            w1 = lerp_q8(w1, w2, tt);
            w0 = lerp_q8(w0, w1, tt);
        end
        r = (w0 + (longint'(1) << (PT_FRAC - 1))) >>> PT_FRAC;
        return r[CW-1:0];
    endfunction

    initial begin
        mismatch_count = 0;
        pending_count  = 0;
    end

    always @(posedge i_clk) begin
        t_point exp_pt;
        t_point new_pt;
        if (i_rst_n) begin
            if (res_valid) begin
                if (expected_points.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected point x=%0d y=%0d", $time, res_x, res_y);
                end else begin
                    exp_pt = expected_points.pop_front();
                    if (res_x !== exp_pt.x || res_y !== exp_pt.y) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                            $display("%0t: point mismatch exp x=%0d y=%0d got x=%0d y=%0d",
                                     $time, exp_pt.x, exp_pt.y, res_x, res_y);
                    end
                end
            end
            if (cmd_start && !cmd_busy) begin
                new_pt.x = axis_point(cmd_action, cmd_p0_x, cmd_p1_x, cmd_p2_x, cmd_p3_x,
                                      cmd_t);
                new_pt.y = axis_point(cmd_action, cmd_p0_y, cmd_p1_y, cmd_p2_y, cmd_p3_y,
                                      cmd_t);
                expected_points.push_back(new_pt);
            end
        end
        pending_count = expected_points.size();
    end

endmodule

/* dv/cubic_bezier_point_eval_tb.sv */
`timescale 1ns / 1ps

module cubic_bezier_point_eval_tb;
    import bcpe_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam int FW = FRAC_BITS_DEF;
    localparam logic [FW:0] T_ONE = {1'b1, {FW{1'b0}}};
    localparam logic [FW:0] T_MAX = '1;
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic ACT_LINE  = 1'b0;
    localparam logic ACT_CUBIC = 1'b1;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_action;
    logic signed [CW-1:0] i_p0_x, i_p0_y, i_p1_x, i_p1_y;
    logic signed [CW-1:0] i_p2_x, i_p2_y, i_p3_x, i_p3_y;
    logic [FW:0]          i_t;
    logic                 o_valid;
    logic signed [CW-1:0] o_point_x, o_point_y;
    int                   mismatch_count;
    int                   pending_count;
    bit                   allow_gaps;

    cubic_bezier_point_eval u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_action  (i_action),
        .i_p0_x    (i_p0_x),
        .i_p0_y    (i_p0_y),
        .i_p1_x    (i_p1_x),
        .i_p1_y    (i_p1_y),
        .i_p2_x    (i_p2_x),
        .i_p2_y    (i_p2_y),
        .i_p3_x    (i_p3_x),
        .i_p3_y    (i_p3_y),
        .i_t       (i_t),
        .o_valid   (o_valid),
        .o_point_x (o_point_x),
        .o_point_y (o_point_y)
    );

    bezier_point_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .cmd_start      (start),
        .cmd_busy       (busy),
        .cmd_action     (i_action),
        .cmd_p0_x       (i_p0_x),
        .cmd_p0_y       (i_p0_y),
        .cmd_p1_x       (i_p1_x),
        .cmd_p1_y       (i_p1_y),
        .cmd_p2_x       (i_p2_x),
        .cmd_p2_y       (i_p2_y),
        .cmd_p3_x       (i_p3_x),
        .cmd_p3_y       (i_p3_y),
        .cmd_t          (i_t),
        .res_valid      (o_valid),
        .res_x          (o_point_x),
        .res_y          (o_point_y),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

    // returns at the transfer edge with start still high, or after a random gap with start low
    task automatic issue_point(
        input logic act,
        input logic signed [CW-1:0] x0, input logic signed [CW-1:0] y0,
        input logic signed [CW-1:0] x1, input logic signed [CW-1:0] y1,
        input logic signed [CW-1:0] x2, input logic signed [CW-1:0] y2,
        input logic signed [CW-1:0] x3, input logic signed [CW-1:0] y3,
        input logic [FW:0] tv
    );
        start    <= 1'b1;
        i_action <= act;
        i_p0_x   <= x0;
        i_p0_y   <= y0;
        i_p1_x   <= x1;
        i_p1_y   <= y1;
        i_p2_x   <= x2;
        i_p2_y   <= y2;
        i_p3_x   <= x3;
        i_p3_y   <= y3;
        i_t      <= tv;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (allow_gaps && $urandom_range(99) < 14) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        logic signed [CW-1:0] v;
        v = CW'($urandom);
        case ($urandom_range(9))
            0: v = C_MIN;
            1: v = C_MAX;
            2, 3: v = CW'($urandom_range(200) - 100);
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [FW:0] rand_t();
        logic [FW:0] v;
        v = (FW+1)'($urandom_range(T_ONE));
        case ($urandom_range(19))
            0: v = '0;
            1: v = T_ONE;
            2: v = T_ONE - 1;
            3, 4: v = (FW+1)'($urandom_range(T_MAX, T_ONE + 1));
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        logic signed [CW-1:0] lx, ly;
        allow_gaps = 1'b1;
        i_rst_n  <= 1'b0;
        start    <= 1'b0;
        i_action <= ACT_LINE;
        i_p0_x   <= '0;
        i_p0_y   <= '0;
        i_p1_x   <= '0;
        i_p1_y   <= '0;
        i_p2_x   <= '0;
        i_p2_y   <= '0;
        i_p3_x   <= '0;
        i_p3_y   <= '0;
        i_t      <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lines: end points, midpoint rounding, t clamped above one
        issue_point(ACT_LINE, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, '0);
        issue_point(ACT_LINE, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, T_ONE);
        issue_point(ACT_LINE, C_MIN, C_MIN, C_MAX, C_MAX, '0, '0, '0, '0, T_ONE / 2);
        issue_point(ACT_LINE, -3, 3, 4, -4, C_MIN, C_MAX, C_MAX, C_MIN, T_MAX);
        issue_point(ACT_LINE, 10, -7, 11, -8, '0, '0, '0, '0, T_ONE + 1);
        // p2 and p3 must not matter for a line
        issue_point(ACT_LINE, 100, -200, -300, 400, '0, '0, '0, '0, 12345);
        issue_point(ACT_LINE, 100, -200, -300, 400, C_MAX, C_MIN, C_MIN, C_MAX, 12345);
        // cubic
        issue_point(ACT_CUBIC, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, '0);
        issue_point(ACT_CUBIC, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, T_ONE);
        issue_point(ACT_CUBIC, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
                    T_ONE / 2);
        issue_point(ACT_CUBIC, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                    T_ONE - 1);
        issue_point(ACT_CUBIC, 1, -1, 2, -2, 3, -3, 4, -4, 1);
        issue_point(ACT_CUBIC, -5, 5, 7, -7, C_MAX, C_MIN, 9, 9, T_ONE + 1);
        issue_point(ACT_CUBIC, 0, 0, 100, 100, -100, -100, 1, 1, T_MAX);
        issue_point(ACT_CUBIC, '0, '0, '0, '0, '0, '0, '0, '0, T_ONE / 3);
        issue_point(ACT_CUBIC, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                    T_ONE / 2);
        issue_point(ACT_CUBIC, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                    T_ONE / 2 + 1);
        issue_point(ACT_CUBIC, -1, -1, -1, -1, -1, -1, -1, -1, T_MAX);

        for (int n = 0; n < 900; n++) begin
            allow_gaps = !(n >= 300 && n < 500);
            if ($urandom_range(1)) begin
                issue_point(ACT_CUBIC, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_t());
            end else begin
                lx = rand_coord();
                ly = rand_coord();
                issue_point(ACT_LINE, lx, ly, rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_t());
            end
        end
        start <= 1'b0;

        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
